// ===== rtl/core/opsb_pkg.sv =====
// Shared types, constants and codes for the odd-only prime sieve bitmap unit.
`timescale 1ns / 1ps
package opsb_pkg;

    localparam int MAX_NUMBER_DEF = 65536;

    localparam int LIM_W   = 17;  // sieve limit register
    localparam int NUM_W   = 16;  // queried number
    localparam int STAT_W  = 2;   // result status
    localparam int WORD_W  = 32;  // bitmap word
    localparam int BSEL_W  = 5;   // bit select inside a bitmap word
    localparam int N_W     = 10;  // sieving prime candidate, n*n below 2^17
    localparam int SQ_W    = 18;  // n*n and the running multiple k
    localparam int POS_W   = 17;  // bit position (k+3)/2
    localparam int PWORD_W = POS_W - BSEL_W;  // word index taken from a bit position

    localparam logic [LIM_W-1:0] LIMIT_RESET = 17'h10000;

    localparam logic REQ_BUILD = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_BUILT = 2'd2;

    localparam logic [N_W-1:0]    FIRST_N    = 10'd3;
    localparam logic [SQ_W-1:0]   FIRST_SQ   = 18'd9;
    localparam logic [NUM_W-1:0]  NUM_TWO    = 16'd2;
    // word 0 after clearing: bit position 2 holds the number 1, which is composite
    localparam logic [WORD_W-1:0] WORD0_INIT = 32'h0000_0004;

    typedef enum logic [3:0] {
        S_IDLE,
        S_QRES,
        S_CLEAR,
        S_NCHK,
        S_NTEST,
        S_MRD,
        S_MLOAD,
        S_MACC,
        S_BRES
    } t_state;

    typedef struct packed {
        logic q_start;    // latch query result fields, read the number's word
        logic b_start;    // start a build: reset clear pointer and n
        logic clr_step;   // write one cleared word, advance pointer
        logic n_rd;       // read the word holding n
        logic n_next;     // n += 2, n*n updated
        logic m_start;    // k = n*n, position of k
        logic m_rd;       // read the word holding the current position
        logic m_load;     // take read word into buffer, set bit, advance k
        logic m_acc;      // set bit in buffer, advance k
        logic m_flush;    // write buffer back
        logic set_ready;  // build finished
        logic out_load;   // move pending result into output register
    } t_cmd;

    typedef struct packed {
        logic req_query;  // offered word is a query
        logic clr_last;   // clear pointer at last bitmap word
        logic sq_done;    // n*n reached the limit
        logic n_marked;   // n is composite
        logic k_more;     // k still below the limit
        logic same_word;  // current position lies in the buffered word
        logic out_free;   // output register can take a word this cycle
    } t_stat;

endpackage

// ===== rtl/core/odd_prime_sieve_bitmap_unit.sv =====
// Query: word accepted in idle, result loaded into the output register in S_QRES once it is free;
// no new word is taken until the unit is back in idle. Build: clears all MAX_NUMBER/2+2 bitmap
// bits one 32-bit word per cycle (1025 words at default), then marks odd multiples by
// read-modify-write on the single RAM port pair, merging hits in the same word.
// Output stall delays the return to idle. Sync active-low reset clears FSM, built flag, output
// valid and sets limit 65536; bitmap not cleared, queries report not built until a build.
`timescale 1ns / 1ps
module odd_prime_sieve_bitmap_unit import opsb_pkg::*; #(
    parameter int MAX_NUMBER = MAX_NUMBER_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [LIM_W-1:0]  i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_req_type,
    input  logic [NUM_W-1:0]  i_number,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_is_prime,
    output logic [STAT_W-1:0] o_status
);

    t_cmd  w_cmd;
    t_stat w_stat;

    opsb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    opsb_dp #(
        .MAX_NUMBER (MAX_NUMBER)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_req_type    (i_req_type),
        .i_number      (i_number),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_is_prime    (o_is_prime),
        .o_status      (o_status)
    );

endmodule

// ===== rtl/core/opsb_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps
module opsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/opsb_ctrl.sv =====
// Controller state machine: sequences queries, bitmap clear and the marking passes.
`timescale 1ns / 1ps
module opsb_ctrl import opsb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_stat.req_query) begin
                        o_cmd.q_start = 1'b1;
                        n_state       = S_QRES;
                    end else begin
                        o_cmd.b_start = 1'b1;
                        n_state       = S_CLEAR;
                    end
                end
            end
            S_QRES: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_NCHK;
                end
            end
            S_NCHK: begin
                if (i_stat.sq_done) begin
                    o_cmd.set_ready = 1'b1;
                    n_state         = S_BRES;
                end else begin
                    o_cmd.n_rd = 1'b1;
                    n_state    = S_NTEST;
                end
            end
            S_NTEST: begin
                if (i_stat.n_marked) begin
                    o_cmd.n_next = 1'b1;
                    n_state      = S_NCHK;
                end else begin
                    o_cmd.m_start = 1'b1;
                    n_state       = S_MRD;
                end
            end
            S_MRD: begin
                o_cmd.m_rd = 1'b1;
                n_state    = S_MLOAD;
            end
            S_MLOAD: begin
                o_cmd.m_load = 1'b1;
                n_state      = S_MACC;
            end
            S_MACC: begin
                if (i_stat.k_more && i_stat.same_word) begin
                    o_cmd.m_acc = 1'b1;
                end else begin
                    // write back and, if k is still below the limit, fetch the next word in the same cycle
                    o_cmd.m_flush = 1'b1;
                    if (i_stat.k_more) begin
                        o_cmd.m_rd = 1'b1;
                        n_state    = S_MLOAD;
                    end else begin
                        o_cmd.n_next = 1'b1;
                        n_state      = S_NCHK;
                    end
                end
            end
            S_BRES: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/opsb_dp.sv =====
// Datapath: limit register, bitmap RAM, sieve counters, word buffer and output register.
`timescale 1ns / 1ps
module opsb_dp import opsb_pkg::*; #(
    parameter int MAX_NUMBER = MAX_NUMBER_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic              i_req_type,
    input  logic [NUM_W-1:0]  i_number,
    input  logic              i_cfg_wr_en,
    input  logic [LIM_W-1:0]  i_cfg_wr_data,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic              o_is_prime,
    output logic [STAT_W-1:0] o_status
);

    localparam int CB_BITS  = MAX_NUMBER / 2 + 2;
    localparam int CB_WORDS = (CB_BITS + WORD_W - 1) / WORD_W;
    localparam int AW       = (CB_WORDS > 1) ? $clog2(CB_WORDS) : 1;
    localparam logic [LIM_W-1:0] MAX_SAT =
        (MAX_NUMBER >= (1 << LIM_W)) ? {LIM_W{1'b1}} : LIM_W'(MAX_NUMBER);
    localparam logic [AW-1:0] LAST_WORD = AW'(CB_WORDS - 1);

    logic [LIM_W-1:0]  r_limit;
    logic              r_ready;
    logic              r_out_valid;
    logic              r_out_prime;
    logic [STAT_W-1:0] r_out_status;
    logic              r_q_prime;
    logic [STAT_W-1:0] r_q_status;
    logic              r_q_use_bit;
    logic [BSEL_W-1:0] r_q_bsel;
    logic [AW-1:0]     r_clr_addr;
    logic [N_W-1:0]    r_n;
    logic [SQ_W-1:0]   r_sq;
    logic [SQ_W-1:0]   r_k;
    logic [POS_W-1:0]  r_pos;
    logic [WORD_W-1:0] r_buf;
    logic [PWORD_W-1:0] r_wword;

    logic [LIM_W-1:0]   w_eff;
    logic [POS_W-1:0]   w_qpos;
    logic [POS_W-1:0]   w_npos;
    logic [SQ_W-1:0]    w_sqpos;
    logic               w_in_range;
    logic [WORD_W-1:0]  w_bit;
    logic               w_ram_wr;
    logic [AW-1:0]      w_ram_waddr;
    logic [WORD_W-1:0]  w_ram_wdata;
    logic               w_ram_rd;
    logic [PWORD_W-1:0] w_rword;
    logic [WORD_W-1:0]  w_rdata;
    logic               w_out_free;

    assign w_eff      = (r_limit > MAX_SAT) ? MAX_SAT : r_limit;
    assign w_qpos     = POS_W'(({1'b0, i_number} + POS_W'(3)) >> 1);
    assign w_npos     = POS_W'((POS_W'(r_n) + POS_W'(3)) >> 1);
    assign w_sqpos    = (r_sq + SQ_W'(3)) >> 1;
    assign w_in_range = ({1'b0, i_number} < w_eff);
    assign w_bit      = WORD_W'(1) << r_pos[BSEL_W-1:0];
    assign w_out_free = !r_out_valid || !i_out_stall;

    // read port: query word, word of n, or word of the running multiple
    assign w_ram_rd = i_cmd.q_start || i_cmd.n_rd || i_cmd.m_rd;
    always_comb begin
        if (i_cmd.q_start) begin
            w_rword = w_qpos[POS_W-1:BSEL_W];
        end else if (i_cmd.n_rd) begin
            w_rword = w_npos[POS_W-1:BSEL_W];
        end else begin
            w_rword = r_pos[POS_W-1:BSEL_W];
        end
    end

    assign w_ram_wr    = i_cmd.clr_step || i_cmd.m_flush;
    assign w_ram_waddr = i_cmd.clr_step ? r_clr_addr : AW'(r_wword);
    always_comb begin
        if (i_cmd.clr_step) begin
            w_ram_wdata = (r_clr_addr == '0) ? WORD0_INIT : '0;
        end else begin
            w_ram_wdata = r_buf;
        end
    end

    opsb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CB_WORDS),
        .AW    (AW)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_wr),
        .i_wr_addr (w_ram_waddr),
        .i_wr_data (w_ram_wdata),
        .i_rd_en   (w_ram_rd),
        .i_rd_addr (AW'(w_rword)),
        .o_rd_data (w_rdata)
    );

    assign o_stat.req_query = (i_req_type == REQ_QUERY);
    assign o_stat.clr_last  = (r_clr_addr == LAST_WORD);
    assign o_stat.sq_done   = (r_sq >= SQ_W'(w_eff));
    assign o_stat.n_marked  = w_rdata[w_npos[BSEL_W-1:0]];
    assign o_stat.k_more    = (r_k < SQ_W'(w_eff));
    assign o_stat.same_word = (r_pos[POS_W-1:BSEL_W] == r_wword);
    assign o_stat.out_free  = w_out_free;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RESET;
            r_ready     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
                r_ready <= 1'b0;
            end else if (i_cmd.set_ready) begin
                r_ready <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and sieve counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_start) begin
            r_q_bsel    <= w_qpos[BSEL_W-1:0];
            r_q_use_bit <= r_ready && w_in_range && i_number[0];
            r_q_prime   <= r_ready && w_in_range && (i_number == NUM_TWO);
            if (!r_ready) begin
                r_q_status <= ST_NOT_BUILT;
            end else if (!w_in_range) begin
                r_q_status <= ST_RANGE;
            end else begin
                r_q_status <= ST_OK;
            end
        end
        if (i_cmd.b_start) begin
            r_q_use_bit <= 1'b0;
            r_q_prime   <= 1'b0;
            r_q_status  <= ST_OK;
            r_clr_addr  <= '0;
            r_n         <= FIRST_N;
            r_sq        <= FIRST_SQ;
        end
        if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
        if (i_cmd.n_next) begin
            // (n+2)^2 = n^2 + 4n + 4
            r_n  <= r_n + N_W'(2);
            r_sq <= r_sq + (SQ_W'(r_n) << 2) + SQ_W'(4);
        end
        if (i_cmd.m_start) begin
            r_k   <= r_sq;
            r_pos <= w_sqpos[POS_W-1:0];
        end
        if (i_cmd.m_load || i_cmd.m_acc) begin
            // advance to the next odd multiple: k += 2n, position += n
            r_k   <= r_k + (SQ_W'(r_n) << 1);
            r_pos <= r_pos + POS_W'(r_n);
        end
        if (i_cmd.m_load) begin
            r_buf   <= w_rdata | w_bit;
            r_wword <= r_pos[POS_W-1:BSEL_W];
        end else if (i_cmd.m_acc) begin
            r_buf <= r_buf | w_bit;
        end
        if (i_cmd.out_load) begin
            r_out_prime  <= r_q_use_bit ? !w_rdata[r_q_bsel] : r_q_prime;
            r_out_status <= r_q_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_is_prime  = r_out_prime;
    assign o_status    = r_out_status;

endmodule

// ===== rtl/core/opsb_chk.sv =====
// Port-level checker for the sieve unit, bound to the top level.
`timescale 1ns / 1ps
module opsb_chk import opsb_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_is_prime,
    input logic [STAT_W-1:0] o_status
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_is_prime) && $stable(o_status))
        else $error("result word changed while stalled");

    // prime only reported with ok status
    a_prime_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_prime |-> o_status == ST_OK)
        else $error("prime flag with non-ok status");

    // one word in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    // reset drops the result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind odd_prime_sieve_bitmap_unit opsb_chk u_opsb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_is_prime  (o_is_prime),
    .o_status    (o_status)
);

// ===== tb/sv/odd_prime_sieve_bitmap_unit_tb.sv =====
// Self-checking testbench for the odd-only prime sieve bitmap unit: builds and queries.
`timescale 1ns / 1ps
module odd_prime_sieve_bitmap_unit_tb import opsb_pkg::*; ();

    // a full build at the top limit runs well under this many quiet cycles
    localparam int WATCHDOG_LIMIT = 600000;
    localparam int MAX_GAP        = 8;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_WORDS    = 67;

    typedef struct packed {
        logic              is_prime;
        logic [STAT_W-1:0] status;
    } t_answer;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [LIM_W-1:0]  i_cfg_wr_data;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_req_type;
    logic [NUM_W-1:0]  i_number;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_is_prime;
    logic [STAT_W-1:0] o_status;

    t_answer          expected_answers[$];
    bit               number_composite [0:MAX_NUMBER_DEF-1];
    logic [LIM_W-1:0] sieve_limit_q;
    bit               sieve_built;
    bit               no_idle = 1'b0;
    int               err_count = 0;

    odd_prime_sieve_bitmap_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_number      (i_number),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_is_prime    (o_is_prime),
        .o_status      (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned active_limit();
        if (sieve_limit_q > MAX_NUMBER_DEF) begin
            return MAX_NUMBER_DEF;
        end
        return 32'(sieve_limit_q);
    endfunction

    // Mark odd composites below the limit, sieving from n*n.
    function automatic void run_sieve();
        int unsigned lim;
        lim = active_limit();
        foreach (number_composite[i]) number_composite[i] = 1'b0;
        number_composite[1] = 1'b1;
        for (int unsigned n = 3; n * n < lim; n += 2) begin
            if (!number_composite[n]) begin
                for (int unsigned k = n * n; k < lim; k += 2 * n) begin
                    number_composite[k] = 1'b1;
                end
            end
        end
        sieve_built = 1'b1;
    endfunction

    function automatic t_answer sieve_answer(logic req, logic [NUM_W-1:0] num);
        t_answer a;
        a.is_prime = 1'b0;
        a.status   = ST_OK;
        if (req == REQ_BUILD) begin
            run_sieve();
        end else if (!sieve_built) begin
            a.status = ST_NOT_BUILT;
        end else if (num >= active_limit()) begin
            a.status = ST_RANGE;
        end else if (num == NUM_TWO) begin
            a.is_prime = 1'b1;
        end else if (num[0]) begin
            a.is_prime = !number_composite[num];
        end
        return a;
    endfunction

    // Mostly numbers below the limit, some right around it, some anywhere.
    function automatic logic [NUM_W-1:0] pick_number(int unsigned lim);
        int pick;
        int val;
        pick = $urandom_range(0, 9);
        if (pick >= 8 || lim == 0) begin
            return NUM_W'($urandom);
        end
        if (pick >= 6) begin
            val = int'(lim) + int'($urandom_range(0, 3)) - 2;
            if (val < 0) val = 0;
            if (val > 65535) val = 65535;
            return val[NUM_W-1:0];
        end
        return NUM_W'($urandom_range(0, lim - 1));
    endfunction

    task automatic send_word(input logic req, input logic [NUM_W-1:0] num);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_req_type = req;
        i_number   = num;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        expected_answers.push_back(sieve_answer(req, num));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_answers.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        sieve_limit_q = value;
        sieve_built   = 1'b0;
    endtask

    task automatic test_query_before_build();
        send_word(REQ_QUERY, 16'd0);
        send_word(REQ_QUERY, 16'hFFFF);
    endtask

    task automatic test_full_build();
        send_word(REQ_BUILD, 16'hFFFF);
        send_word(REQ_QUERY, 16'd0);
        send_word(REQ_QUERY, 16'd1);
        send_word(REQ_QUERY, 16'd2);
        send_word(REQ_QUERY, 16'd4);
        send_word(REQ_QUERY, 16'd9);
        send_word(REQ_QUERY, 16'd65521);
        send_word(REQ_QUERY, 16'hFFFF);
    endtask

    task automatic test_range_limit();
        write_limit(17'd100);
        send_word(REQ_BUILD, 16'd0);
        send_word(REQ_QUERY, 16'd97);
        send_word(REQ_QUERY, 16'd99);
        send_word(REQ_QUERY, 16'd100);
    endtask

    task automatic test_limit_rewrite();
        write_limit(17'd3);
        send_word(REQ_QUERY, 16'd2);
        send_word(REQ_BUILD, 16'h5A5A);
        send_word(REQ_QUERY, 16'd2);
        send_word(REQ_QUERY, 16'd3);
    endtask

    task automatic test_tiny_limits();
        write_limit(17'd2);
        send_word(REQ_BUILD, 16'hA5A5);
        send_word(REQ_QUERY, 16'd1);
        send_word(REQ_QUERY, 16'd2);
        write_limit(17'd0);
        send_word(REQ_BUILD, 16'd0);
        send_word(REQ_QUERY, 16'd0);
    endtask

    task automatic test_saturated_limit();
        write_limit(17'h1FFFF);
        send_word(REQ_BUILD, 16'd0);
        send_word(REQ_QUERY, 16'd65521);
    endtask

    task automatic test_random_phases();
        int unsigned lim;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 9))
                0: lim = $urandom_range(0, 2);
                1: lim = $urandom_range(8000, 20000);
                default: lim = $urandom_range(3, 3000);
            endcase
            write_limit(lim[LIM_W-1:0]);
            no_idle = (p == 1) || ($urandom_range(0, 3) == 0);
            repeat (2) send_word(REQ_QUERY, NUM_W'($urandom));
            send_word(REQ_BUILD, NUM_W'($urandom));
            repeat (PHASE_WORDS) begin
                if ($urandom_range(0, 24) == 0) begin
                    send_word(REQ_BUILD, NUM_W'($urandom));
                end else begin
                    send_word(REQ_QUERY, pick_number(active_limit()));
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin : result_checker
        t_answer want;
        int      hold;
        bit      seen_valid;
        i_out_stall = 1'b0;
        hold = 0;
        forever begin
            @(posedge i_clk);
            seen_valid = i_rst_n && (o_out_valid === 1'b1);
            if (seen_valid && i_out_stall == 1'b0) begin
                if (expected_answers.size() == 0) begin
                    $error("result with nothing expected: is_prime %0b status %0d",
                           o_is_prime, o_status);
                    err_count++;
                end else begin
                    want = expected_answers.pop_front();
                    if (o_is_prime !== want.is_prime) begin
                        $error("is_prime: expected %0b, actual %0b", want.is_prime, o_is_prime);
                        err_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        err_count++;
                    end
                end
                hold = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            end else if (seen_valid && hold > 0) begin
                // spend the stall only while a word is waiting
                hold--;
            end
            @(negedge i_clk);
            i_out_stall = (hold > 0);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && !i_out_stall) || i_cfg_wr_en) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("odd_prime_sieve_bitmap_unit_tb: done, errors");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid    = 1'b0;
        i_req_type    = REQ_QUERY;
        i_number      = '0;
        sieve_limit_q = LIMIT_RESET;
        sieve_built   = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_query_before_build();
        test_full_build();
        test_range_limit();
        test_limit_rewrite();
        test_tiny_limits();
        test_saturated_limit();
        test_random_phases();

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (err_count == 0 && expected_answers.size() == 0) begin
            $display("odd_prime_sieve_bitmap_unit_tb: done, clean");
        end else begin
            $display("odd_prime_sieve_bitmap_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
